>>> design/assert_macros.svh
// Assertion macros shared by the address decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define MSAD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define MSAD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define MSAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/msad_pkg.sv
// Package with the types and constants of the ModRM/SIB address decoder.
`default_nettype none

package msad_pkg;

  localparam int GPR_COUNT = 8;
  localparam int GPR_IDX_W = $clog2(GPR_COUNT);
  localparam int GPR_W     = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 88;

  localparam logic [7:0] MODRM_MOD_MASK = 8'hC0;
  localparam logic [7:0] MODRM_REG_MASK = 8'h38;
  localparam logic [7:0] MODRM_RM_MASK  = 8'h07;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP32  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  localparam logic [2:0] RM_SIB       = 3'd4;
  localparam logic [2:0] RM_DISP_ONLY = 3'd5;
  localparam logic [2:0] SIB_NO_BASE  = 3'd5;
  localparam logic [2:0] SIB_NO_INDEX = 3'd4;

  localparam logic [2:0] DISP8_BYTES  = 3'd1;
  localparam logic [2:0] DISP32_BYTES = 3'd4;

  localparam logic CMD_REG_WRITE = 1'b0;
  localparam logic CMD_CODE_BYTE = 1'b1;

  typedef enum logic [2:0] {
    PH_MODRM = 3'b001,
    PH_SIB   = 3'b010,
    PH_DISP  = 3'b100
  } msad_phase_t;

  typedef struct packed {
    logic [1:0]           mod_bits;
    logic [2:0]           reg_bits;
    logic [2:0]           rm_bits;
    logic                 has_sib;
    logic [1:0]           scale_shift;
    logic [2:0]           index_reg;
    logic [2:0]           base_reg;
    logic [31:0]          displacement;
    logic                 is_register;
    logic [2:0]           operand_length;
    logic                 use_base;
    logic                 use_index;
    logic [GPR_IDX_W-1:0] base_sel;
  } msad_result_t;

endpackage

`default_nettype wire

>>> design/msad_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module msad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

>>> design/msad_decode.sv
// Byte-stream sequencer that gathers ModRM, SIB and displacement bytes.
`default_nettype none

module msad_decode (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_en,
  input  wire logic [7:0]            code_byte,
  output logic                       finish,
  output msad_pkg::msad_result_t     res
);

  import msad_pkg::*;

  `include "assert_macros.svh"

  msad_phase_t phase_r, phase_nxt;
  logic [15:0] fields_r, fields_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  count_r, count_nxt;

  logic [1:0]  code_mod;
  logic [2:0]  code_rm;
  logic [1:0]  cur_mod;
  logic [2:0]  disp_total;
  logic [1:0]  disp_pos;

  assign code_mod   = 2'((code_byte & MODRM_MOD_MASK) >> 6);
  assign code_rm    = 3'(code_byte & MODRM_RM_MASK);
  assign cur_mod    = fields_r[15:14];
  assign disp_total = (cur_mod == MOD_DISP8) ? DISP8_BYTES : DISP32_BYTES;
  assign disp_pos   = 2'(disp_total - left_r);

  always_comb begin
    phase_nxt  = phase_r;
    fields_nxt = fields_r;
    accum_nxt  = accum_r;
    left_nxt   = left_r;
    count_nxt  = count_r;
    finish     = 1'b0;
    if (byte_en) begin
      case (phase_r)
        PH_SIB: begin
          fields_nxt = {fields_r[15:8], code_byte};
          count_nxt  = 3'd2;
          if (cur_mod == MOD_DISP8) begin
            left_nxt = DISP8_BYTES;
          end else if (cur_mod == MOD_DISP32 || code_byte[2:0] == SIB_NO_BASE) begin
            left_nxt = DISP32_BYTES;
          end else begin
            left_nxt = 3'd0;
          end
          if (left_nxt == 3'd0) begin
            finish    = 1'b1;
            phase_nxt = PH_MODRM;
          end else begin
            phase_nxt = PH_DISP;
          end
        end
        PH_DISP: begin
          accum_nxt = accum_r | (32'(code_byte) << {disp_pos, 3'b000});
          count_nxt = count_r + 3'd1;
          left_nxt  = left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            finish    = 1'b1;
            phase_nxt = PH_MODRM;
          end
        end
        default: begin
          fields_nxt = {code_byte, 8'h00};
          accum_nxt  = 32'd0;
          count_nxt  = 3'd1;
          if (code_mod != MOD_REG && code_rm == RM_SIB) begin
            phase_nxt = PH_SIB;
          end else begin
            if (code_mod == MOD_DISP8) begin
              left_nxt = DISP8_BYTES;
            end else if (code_mod == MOD_DISP32 ||
                         (code_mod == MOD_NO_DISP && code_rm == RM_DISP_ONLY)) begin
              left_nxt = DISP32_BYTES;
            end else begin
              left_nxt = 3'd0;
            end
            if (left_nxt == 3'd0) begin
              finish    = 1'b1;
              phase_nxt = PH_MODRM;
            end else begin
              phase_nxt = PH_DISP;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res.mod_bits       = fields_nxt[15:14];
    res.reg_bits       = 3'((fields_nxt[15:8] & MODRM_REG_MASK) >> 3);
    res.rm_bits        = 3'(fields_nxt[15:8] & MODRM_RM_MASK);
    res.has_sib        = (res.mod_bits != MOD_REG) && (res.rm_bits == RM_SIB);
    res.scale_shift    = res.has_sib ? fields_nxt[7:6] : 2'd0;
    res.index_reg      = res.has_sib ? fields_nxt[5:3] : 3'd0;
    res.base_reg       = res.has_sib ? fields_nxt[2:0] : 3'd0;
    res.is_register    = (res.mod_bits == MOD_REG);
    res.operand_length = count_nxt;
    case (res.mod_bits)
      MOD_DISP8: res.displacement = {{24{accum_nxt[7]}}, accum_nxt[7:0]};
      MOD_REG:   res.displacement = 32'd0;
      default:   res.displacement = accum_nxt;
    endcase
    if (res.has_sib) begin
      res.use_base = !(res.mod_bits == MOD_NO_DISP && res.base_reg == SIB_NO_BASE);
      res.base_sel = GPR_IDX_W'(res.base_reg);
    end else begin
      res.use_base = !res.is_register &&
                     !(res.mod_bits == MOD_NO_DISP && res.rm_bits == RM_DISP_ONLY);
      res.base_sel = GPR_IDX_W'(res.rm_bits);
    end
    res.use_index = res.has_sib && (res.index_reg != SIB_NO_INDEX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MODRM;
      fields_r <= 16'd0;
      accum_r  <= 32'd0;
      left_r   <= 3'd0;
      count_r  <= 3'd0;
    end else begin
      phase_r  <= phase_nxt;
      fields_r <= fields_nxt;
      accum_r  <= accum_nxt;
      left_r   <= left_nxt;
      count_r  <= count_nxt;
    end
  end

  `MSAD_ASSERT_ALWAYS(a_phase_onehot, $onehot(phase_r), "Decode phase is not one-hot.")
  `MSAD_ASSERT_SAME(a_disp_left, phase_r == PH_DISP,
    left_r != 3'd0 && left_r <= DISP32_BYTES, "Displacement phase with bad byte count.")
  `MSAD_ASSERT_NEXT(a_finish_idle, finish, phase_r == PH_MODRM && left_r == 3'd0,
    "Decoder did not return to ModRM after an operand.")

endmodule

`default_nettype wire

>>> design/modrm_sib_address_decoder_unit.sv
// Top level of the 32-bit ModRM/SIB effective address decoder.
//
//   Port group   Direction   tdata fields (low bit first)                 tuser
//   in_*         slave       code_byte, reg_select, reg_value             command
//   out_*        master      mod, reg, rm, has_sib, scale, index, base,   is_register
//                            displacement, effective_address, length
//
// A transaction may be accepted in every cycle unless stalled; an operand then passes both stages.
// The decode state and the register copy update at the accepting edge, which also reads the copy.
// The middle stage adds base, scaled index and displacement into the output register.
// Reset clears the decode state and marks all eight register copies as zero.
// A stall on the output holds both stages, and the input is ready whenever the middle stage can move.
`default_nettype none

module modrm_sib_address_decoder_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // code_byte [7:0], reg_select [10:8], reg_value [42:11], zero [47:43]
  input  wire logic [msad_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command [0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // mod_bits [1:0], reg_bits [4:2], rm_bits [7:5], has_sib [8], scale_shift [10:9],
  // index_reg [13:11], base_reg [16:14], displacement [48:17],
  // effective_address [80:49], operand_length [83:81], zero [87:84]
  output logic      [msad_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // is_register [0]
  output logic                                    out_tuser
);

  import msad_pkg::*;

  `include "assert_macros.svh"

  logic                 in_acc;
  logic                 code_en;
  logic                 reg_wr;
  logic [7:0]           in_code;
  logic [GPR_IDX_W-1:0] in_sel;
  logic [GPR_W-1:0]     in_value;
  logic                 finish;
  logic                 rd_en;
  msad_result_t         res;

  logic [GPR_COUNT-1:0] gpr_vld_r, gpr_vld_nxt;
  logic [GPR_W-1:0]     rd_base, rd_index;

  logic                 mid_valid_r, mid_valid_nxt;
  msad_result_t         mid_r;
  logic                 base_ok_r, index_ok_r;
  logic                 mid_adv;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                 out_user_r;
  logic [31:0]          base_term, index_term, ea;

  assign in_code  = in_tdata[7:0];
  assign in_sel   = in_tdata[10:8];
  assign in_value = in_tdata[42:11];

  assign in_tready = !mid_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign code_en   = in_acc && (in_tuser == CMD_CODE_BYTE);
  assign reg_wr    = in_acc && (in_tuser == CMD_REG_WRITE);
  assign rd_en     = code_en && finish;

  msad_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (code_en),
    .code_byte (in_code),
    .finish    (finish),
    .res       (res)
  );

  msad_ram #(
    .WIDTH (GPR_W),
    .DEPTH (GPR_COUNT)
  ) u_gpr_ram (
    .clk     (clk),
    .we      (reg_wr),
    .waddr   (in_sel),
    .wdata   (in_value),
    .re      (rd_en),
    .raddr_a (res.base_sel),
    .raddr_b (GPR_IDX_W'(res.index_reg)),
    .rdata_a (rd_base),
    .rdata_b (rd_index)
  );

  always_comb begin
    gpr_vld_nxt = gpr_vld_r;
    if (reg_wr) begin
      gpr_vld_nxt[in_sel] = 1'b1;
    end
  end

  assign mid_adv = mid_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    mid_valid_nxt = mid_valid_r;
    if (rd_en) begin
      mid_valid_nxt = 1'b1;
    end else if (mid_adv) begin
      mid_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (mid_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign base_term  = base_ok_r ? rd_base : 32'd0;
  assign index_term = index_ok_r ? (rd_index << mid_r.scale_shift) : 32'd0;
  assign ea         = base_term + index_term + mid_r.displacement;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpr_vld_r   <= '0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gpr_vld_r   <= gpr_vld_nxt;
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mid_r      <= res;
      base_ok_r  <= res.use_base && gpr_vld_r[res.base_sel];
      index_ok_r <= res.use_index && gpr_vld_r[GPR_IDX_W'(res.index_reg)];
    end
    if (mid_adv) begin
      out_data_r <= {4'd0, mid_r.operand_length, ea, mid_r.displacement,
                     mid_r.base_reg, mid_r.index_reg, mid_r.scale_shift, mid_r.has_sib,
                     mid_r.rm_bits, mid_r.reg_bits, mid_r.mod_bits};
      out_user_r <= mid_r.is_register;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `MSAD_ASSERT_SAME(a_mid_no_overrun, mid_valid_r && !mid_adv, !rd_en,
    "A finished operand overwrote a stalled one.")
  `MSAD_ASSERT_NEXT(a_mid_to_out, mid_adv, out_valid_r,
    "A moved operand did not reach the output register.")
  `MSAD_ASSERT_SAME(a_reg_operand_zero, out_valid_r && out_user_r,
    out_data_r[80:17] == 64'd0, "A register operand has a nonzero address or displacement.")

endmodule

`default_nettype wire
